[design/mavg_pkg.sv]
// ----------------------------------------------------------------------------
// Moving average package
// Field widths and parameter defaults shared by the moving average block.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int SAMPLE_W = 12;
  localparam int AVG_W    = 12;
  localparam int USED_W   = 4;

  localparam int WINDOW_DEF      = 10;
  localparam int SAMPLE_BITS_DEF = 12;

endpackage

[design/mavg_if.sv]
// ----------------------------------------------------------------------------
// Moving average channels
// Valid/ready channels for samples in and averages out.
// ----------------------------------------------------------------------------
interface mavg_in_if;
  logic                          valid;
  logic                          ready;
  logic [mavg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mavg_pkg::AVG_W-1:0]  average;
  logic [mavg_pkg::USED_W-1:0] readings_used;

  modport source (output valid, output average, output readings_used, input ready);
  modport sink   (input valid, input average, input readings_used, output ready);
endinterface

[design/moving_average_with_warmup.sv]
// One sample in, one average out: each accepted sample enters a ring of
// WINDOW readings and yields floor(sum / n), where n counts the samples seen
// until the ring fills and is WINDOW from then on. The front end takes no
// new sample until it has pushed the last one's (sum, count) pair; the back
// end divides one quotient bit per cycle, and that divider, not the front
// end, sets the sustained rate. A two-entry queue lets the front end keep
// taking samples while a result waits on the output register.
// ----------------------------------------------------------------------------
// Moving average with warm-up
// Top level: sample ring and running sum, queue, serial divider.
// ----------------------------------------------------------------------------
module moving_average_with_warmup #(
  parameter int WINDOW      = mavg_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mavg_in_if.sink    in_ch,
  mavg_out_if.source out_ch
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic [SUM_W-1:0] f_sum;
  logic [CNT_W-1:0] f_used;
  logic [SUM_W-1:0] b_sum;
  logic [CNT_W-1:0] b_used;

  mavg_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_sum  (f_sum),
    .q_used (f_used),
    .q_full (q_full)
  );

  mavg_queue #(
    .DATA_W (SUM_W + CNT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_sum, f_used}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  ({b_sum, b_used}),
    .empty     (q_empty)
  );

  mavg_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_sum   (b_sum),
    .q_used  (b_used),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (f_used != '0) && (f_used <= CNT_W'(WINDOW)))
    else $error("reading count out of range");

endmodule

[design/mavg_front.sv]
// ----------------------------------------------------------------------------
// Moving average front end
// Accepts samples, keeps the sample ring and running sum, and pushes
// (sum, count) pairs to the divide queue.
// ----------------------------------------------------------------------------
module mavg_front #(
  parameter int WINDOW      = mavg_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mavg_in_if.sink                               in_ch,
  output logic                                  q_push,
  output logic [SAMPLE_BITS+$clog2(WINDOW)-1:0] q_sum,
  output logic [$clog2(WINDOW+1)-1:0]           q_used,
  input  logic                                  q_full
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  front_state_t            state_r, state_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic                    warm_r, warm_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0]  samp_r;
  logic [SAMPLE_BITS-1:0]  old_r;
  logic [SAMPLE_BITS-1:0]  ring [WINDOW];
  logic [SAMPLE_BITS-1:0]  in_samp;
  logic                    in_xfer;
  logic                    warm_after;
  logic [SUM_W-1:0]        drop_val;

  assign in_samp  = SAMPLE_BITS'(in_ch.sample);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == F_IDLE);

  // ring: write new sample, read the entry it replaces
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      old_r        <= ring[slot_r];
      ring[slot_r] <= in_samp;
      samp_r       <= in_samp;
    end
  end

  assign warm_after = warm_r && (slot_r != LAST_SLOT);
  assign drop_val   = warm_r ? '0 : SUM_W'(old_r);
  assign q_sum      = sum_r - drop_val + SUM_W'(samp_r);
  assign q_used     = warm_after ? (CNT_W'(slot_r) + CNT_W'(1)) : CNT_W'(WINDOW);

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    warm_nxt  = warm_r;
    sum_nxt   = sum_r;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (in_xfer) begin
          state_nxt = F_UPD;
        end
      end
      F_UPD: begin
        if (!q_full) begin
          q_push    = 1'b1;
          sum_nxt   = q_sum;
          warm_nxt  = warm_after;
          slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= '0;
      warm_r  <= 1'b1;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      warm_r  <= warm_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

[design/mavg_queue.sv]
// ----------------------------------------------------------------------------
// Moving average queue
// Two-entry FIFO between the front end and the divider.
// ----------------------------------------------------------------------------
module mavg_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int DEPTH = 2;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  assign full     = (count_r == 2'(DEPTH));
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[design/mavg_back.sv]
// ----------------------------------------------------------------------------
// Moving average back end
// Bit-serial restoring divide of sum by count, one quotient bit per cycle,
// into a registered output stage.
// ----------------------------------------------------------------------------
module mavg_back #(
  parameter int WINDOW      = mavg_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  logic [SAMPLE_BITS+$clog2(WINDOW)-1:0] q_sum,
  input  logic [$clog2(WINDOW+1)-1:0]           q_used,
  output logic                                  q_pop,
  mavg_out_if.source                            out_ch
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  back_state_t                  state_r, state_nxt;
  logic [SUM_W-1:0]             quo_r;
  logic [CNT_W-1:0]             rem_r;
  logic [CNT_W-1:0]             div_r;
  logic [STEP_W-1:0]            step_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [mavg_pkg::AVG_W-1:0]   avg_r;
  logic [mavg_pkg::USED_W-1:0]  used_r;
  logic [CNT_W:0]               trial;
  logic                         ge;
  logic [CNT_W:0]               diff;
  logic                         load;
  logic                         out_free;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign load     = (state_r == B_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_DIV;
      B_DIV:  if (step_r == STEP_W'(SUM_W - 1)) state_nxt = B_DONE;
      B_DONE: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // divide datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo_r  <= q_sum;
      div_r  <= q_used;
      rem_r  <= '0;
      step_r <= '0;
    end else if (state_r == B_DIV) begin
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      rem_r  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      avg_r  <= mavg_pkg::AVG_W'(quo_r[SAMPLE_BITS-1:0]);
      used_r <= mavg_pkg::USED_W'(div_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.average       = avg_r;
  assign out_ch.readings_used = used_r;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average with warm-up testbench
// Drives converter samples through the valid/ready input channel, predicts
// the boxcar average and reading count for every transfer, and compares each
// result transfer against the oldest prediction. A short table of directed
// samples exercises warm-up, its end, slot wrap and the sample extremes;
// random samples follow with idle gaps on both sides, a stretch with no gaps
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int SAMPLE_W   = mavg_pkg::SAMPLE_W;
  localparam int AVG_W      = mavg_pkg::AVG_W;
  localparam int USED_W     = mavg_pkg::USED_W;
  localparam int WIN        = mavg_pkg::WINDOW_DEF;
  localparam int DIR_N      = 25;
  localparam int RAND_N     = 1650;
  localparam int IDLE_PCT   = 23;
  localparam int CALM_FIRST = 900;
  localparam int CALM_LAST  = 1200;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_CYC  = 60;

  typedef struct packed {
    logic [AVG_W-1:0]  average;
    logic [USED_W-1:0] readings_used;
  } avg_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    avg_result_t         want;
  } sample_row_t;

  logic clk;
  logic rst_n;

  mavg_in_if  in_ch ();
  mavg_out_if out_ch ();

  moving_average_with_warmup u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // directed samples: warm-up, end of warm-up, wrap, extremes
  sample_row_t sample_table [DIR_N] = '{
    '{12'd4095, 1'b1, '{12'd4095, 4'd1}},
    '{12'd0,    1'b1, '{12'd2047, 4'd2}},
    '{12'd1,    1'b0, '{12'd0,    4'd0}},
    '{12'd2048, 1'b0, '{12'd0,    4'd0}},
    '{12'd4095, 1'b0, '{12'd0,    4'd0}},
    '{12'd2047, 1'b0, '{12'd0,    4'd0}},
    '{12'd4094, 1'b0, '{12'd0,    4'd0}},
    '{12'd1024, 1'b0, '{12'd0,    4'd0}},
    '{12'd3,    1'b0, '{12'd0,    4'd0}},
    '{12'd4095, 1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b0, '{12'd0,    4'd0}},
    '{12'd0,    1'b1, '{12'd0,    4'd10}},
    '{12'd4095, 1'b0, '{12'd0,    4'd0}},
    '{12'd4095, 1'b0, '{12'd0,    4'd0}},
    '{12'd4095, 1'b0, '{12'd0,    4'd0}},
    '{12'd4095, 1'b0, '{12'd0,    4'd0}},
    '{12'd4095, 1'b0, '{12'd0,    4'd0}}
  };

  // predictor state
  logic [SAMPLE_W-1:0] held_readings [WIN];
  int unsigned         next_slot;
  bit                  filling;
  int unsigned         window_sum;

  avg_result_t pending_averages [$];
  int          mismatches;
  bit          calm;
  bit          hold_req;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic avg_result_t predict_average(input logic [SAMPLE_W-1:0] s);
    avg_result_t r;
    int unsigned count;
    if (!filling)
      window_sum -= held_readings[next_slot];
    held_readings[next_slot] = s;
    window_sum += s;
    if (next_slot == WIN - 1)
      filling = 1'b0;
    count = filling ? next_slot + 1 : WIN;
    next_slot = (next_slot + 1 >= WIN) ? 0 : next_slot + 1;
    r.average       = AVG_W'(window_sum / count);
    r.readings_used = USED_W'(count);
    return r;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input avg_result_t want);
    avg_result_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_average(s);
    pending_averages.push_back(typed ? want : pred);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
      3:       return ~(SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1));
      default: return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
    endcase
  endfunction

  // result check
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_averages.size() == 0) begin
        flag_mismatch($sformatf("unexpected result avg=%0d used=%0d",
                                out_ch.average, out_ch.readings_used));
      end else begin
        avg_result_t want;
        want = pending_averages.pop_front();
        if (out_ch.average !== want.average)
          flag_mismatch($sformatf("average %0d, want %0d",
                                  out_ch.average, want.average));
        if (out_ch.readings_used !== want.readings_used)
          flag_mismatch($sformatf("readings_used %0d, want %0d",
                                  out_ch.readings_used, want.readings_used));
      end
    end
  end

  // result side ready
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // sample side and run control
  initial begin
    avg_result_t none;
    none         = '0;
    mismatches   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    next_slot    = 0;
    filling      = 1'b1;
    window_sum   = 0;
    foreach (held_readings[k]) held_readings[k] = '0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (sample_table[k])
      send_sample(sample_table[k].sample, sample_table[k].typed, sample_table[k].want);

    for (int i = 0; i < RAND_N; i++) begin
      calm = (i >= CALM_FIRST) && (i < CALM_LAST);
      if (i == HOLD_AT)
        hold_req = 1'b1;
      send_sample(random_sample(), 1'b0, none);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
